[rtl/core/ps2mpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types, constants and delta decode for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int COORD_BITS_DEF = 13;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 768;

  // Header byte bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

  localparam int DELTA_W = 10;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  // Signed axis delta: two's complement low byte as magnitude, +255 on overflow.
  function automatic logic signed [DELTA_W-1:0] axis_delta(input logic [7:0] b,
                                                           input logic neg,
                                                           input logic ovf);
    logic [7:0]         mag8;
    logic [DELTA_W-1:0] mag;
    mag8 = neg ? (8'd0 - b) : b;
    mag  = {2'b00, mag8} + (ovf ? DELTA_W'(255) : DELTA_W'(0));
    return neg ? $signed(DELTA_W'(0) - mag) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

[rtl/core/ps2mpt_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mpt_in_reg
// Input word register; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module ps2mpt_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       adv,
  output logic            byte_v,
  output logic [7:0]      byte_q
);

  logic       v_r, v_nxt;
  logic [7:0] byte_r;

  assign in_tready = !v_r || adv;
  assign v_nxt     = in_tready ? in_tvalid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_v = v_r;
  assign byte_q = byte_r;

endmodule
`default_nettype wire

[rtl/core/ps2mpt_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mpt_tracker
// Packet framing, cursor position update and clamp; screen size registers.
// ----------------------------------------------------------------------------
module ps2mpt_tracker
  import ps2mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic                  step,
  input  wire logic [7:0]            byte_in,
  output logic                       res_valid,
  output logic [OUT_W-1:0]           res_data
);

  localparam int POS_W = COORD_BITS + 3;
  localparam logic signed [POS_W-1:0] ONE = 1;

  phase_t phase_r, phase_nxt;
  logic [7:0] hdr_r, xd_r;
  logic [COORD_BITS-1:0] width_r, height_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic signed [POS_W-1:0] cand_x, cand_y, top_x, top_y, low_x, low_y;
  logic signed [DELTA_W-1:0] dx, dy;
  logic emit, load_hdr, load_xd;

  // Screen size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= COORD_BITS'(WIDTH_RST);
      height_r <= COORD_BITS'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= width_r;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_XDELTA: phase_nxt = PH_YDELTA;
        PH_YDELTA: phase_nxt = PH_HEADER;
        default:   phase_nxt = byte_in[HDR_SYNC] ? PH_XDELTA : PH_HEADER;
      endcase
    end
  end

  // Phase outputs
  always_comb begin
    emit     = 1'b0;
    load_hdr = 1'b0;
    load_xd  = 1'b0;
    case (phase_r)
      PH_XDELTA: load_xd  = step;
      PH_YDELTA: emit     = step;
      default:   load_hdr = step && byte_in[HDR_SYNC];
    endcase
  end

  // Position math
  always_comb begin
    dx     = axis_delta(xd_r, hdr_r[HDR_XSIGN], hdr_r[HDR_XOVF]);
    dy     = axis_delta(byte_in, hdr_r[HDR_YSIGN], hdr_r[HDR_YOVF]);
    cand_x = pos_x_r + POS_W'(dx);
    cand_y = pos_y_r - POS_W'(dy);
    top_x  = $signed({3'b000, width_r}) - ONE;
    top_y  = $signed({3'b000, height_r}) - ONE;
    low_x  = (cand_x <= ONE) ? ONE : cand_x;
    low_y  = (cand_y <= ONE) ? ONE : cand_y;
    pos_x_nxt = (low_x >= top_x) ? top_x : low_x;
    pos_y_nxt = (low_y >= top_y) ? top_y : low_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= 8'd0;
      xd_r    <= 8'd0;
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (load_hdr) begin
        hdr_r <= byte_in;
      end
      if (load_xd) begin
        xd_r <= byte_in;
      end
      if (emit) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  assign res_valid = emit;
  assign res_data  = OUT_W'({hdr_r[HDR_RIGHT], hdr_r[HDR_MIDDLE], hdr_r[HDR_LEFT],
                             pos_y_nxt[COORD_BITS-1:0], pos_x_nxt[COORD_BITS-1:0]});

endmodule
`default_nettype wire

[rtl/core/ps2mpt_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mpt_out_reg
// Result word register on the master side.
// ----------------------------------------------------------------------------
module ps2mpt_out_reg #(
  parameter int OUT_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic             res_valid,
  input  wire logic [OUT_W-1:0] res_data,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata
);

  logic             v_r, v_nxt;
  logic [OUT_W-1:0] data_r;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = res_valid;
    end else if (out_tready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= res_data;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

[rtl/core/ps2_mouse_packet_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Raw PS/2 mouse bytes in, clamped cursor position and buttons out.
// ----------------------------------------------------------------------------
// Slave side takes one raw mouse byte per word. The tracker syncs on a header
// byte with bit 3 set, then takes the X and Y delta bytes; the Y delta word
// produces one result word, all other bytes produce none.
// Each byte waits in the input register; the result word of a Y delta byte is
// loaded into the result register when that byte advances out of it.
// Throughput: one byte per cycle while out_tready is high, set by the
// combinational delta, add and clamp path between input and result registers.
// The input register refills in the cycle it drains, so with out_tready high
// a byte is taken every cycle. While a result word waits, one more byte is
// taken into the input register; in_tready then stays low until the result
// word is taken.
// Reset clears phase, header, X delta and position to zero and loads the
// screen size registers with 1024 x 768. A size write on cfg_* applies to
// any later Y delta byte. While out_tready is low the result word holds.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
  import ps2mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // data_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cursor_x, cursor_y, left_button, middle_button, right_button, zero pad
  output logic [((2 * COORD_BITS + 3 + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((2 * COORD_BITS + 3 + 7) / 8) * 8;

  logic             byte_v, adv, res_valid;
  logic [7:0]       byte_q;
  logic [OUT_W-1:0] res_data;

  assign adv = byte_v && (!out_tvalid || out_tready);

  ps2mpt_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .byte_v    (byte_v),
    .byte_q    (byte_q)
  );

  ps2mpt_tracker #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W)
  ) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .step      (adv),
    .byte_in   (byte_q),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  ps2mpt_out_reg #(
    .OUT_W (OUT_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/ps2mpt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mpt_checker
// Port-level checks for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
module ps2mpt_checker #(
  parameter int OUT_W = 32
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // a new result word always traces back to a byte taken by the input register
  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without a matching input byte");

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker #(
  .OUT_W (((2 * COORD_BITS + 3 + 7) / 8) * 8)
) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[tb/sv/tb_ps2_mouse_packet_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker
// Self-checking bench for the PS/2 mouse packet tracker. A directed table
// covers sync loss, zero deltas, overflow and sign extremes, clamping at both
// edges and every button. It is followed by random packet streams under
// several screen sizes, random gaps on both sides and one long output stall.
// Every byte the tracker accepts goes through a cursor tracker model here.
// Each result word is compared field by field with the oldest predicted
// cursor word.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;
  import ps2mpt_pkg::*;

  localparam int CW         = COORD_BITS_DEF;
  localparam int OUT_W      = ((2 * CW + 3 + 7) / 8) * 8;
  localparam int STALL_LONG = 120;

  // Laid out to match out_tdata from bit 0 up: x, y, left, middle, right
  typedef struct packed {
    logic          r;
    logic          m;
    logic          l;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } cursor_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    cursor_t    want;
  } stim_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_addr   = CFG_WIDTH;
  logic [CW-1:0]    cfg_data   = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;   // data_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // cursor_x, cursor_y, left, middle, right, pad

  always #5 clk = ~clk;

  ps2_mouse_packet_tracker #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Cursor tracker state
  phase_t        trk_phase = PH_HEADER;
  logic [7:0]    trk_hdr   = '0;
  logic [7:0]    trk_xbyte = '0;
  int            cur_col   = 0;
  int            cur_row   = 0;
  logic [CW-1:0] scr_w     = CW'(WIDTH_RST);
  logic [CW-1:0] scr_h     = CW'(HEIGHT_RST);

  cursor_t   cursor_q[$];
  stim_row_t typed_q[$];
  stim_row_t directed_rows[$];
  int        err_count = 0;
  bit        no_idle   = 1'b0;
  bit        hold_req  = 1'b0;

  function automatic int step_of(logic [7:0] b, logic neg, logic ovf);
    int mag;
    mag = neg ? (256 - int'(b)) % 256 : int'(b);
    if (ovf) mag += 255;
    return neg ? -mag : mag;
  endfunction

  // Lower clamp first, so a tiny screen ends at size - 1
  function automatic int pin_to_screen(int p, logic [CW-1:0] size);
    int top;
    top = int'(size) - 1;
    if (p <= 1) p = 1;
    if (p >= top) p = top;
    return p;
  endfunction

  function automatic bit track_byte(input logic [7:0] b, output cursor_t c);
    c = '0;
    case (trk_phase)
      PH_XDELTA: begin
        trk_xbyte = b;
        trk_phase = PH_YDELTA;
        return 1'b0;
      end
      PH_YDELTA: begin
        trk_phase = PH_HEADER;
        cur_col = pin_to_screen(cur_col + step_of(trk_xbyte, trk_hdr[HDR_XSIGN],
                                                  trk_hdr[HDR_XOVF]), scr_w);
        cur_row = pin_to_screen(cur_row - step_of(b, trk_hdr[HDR_YSIGN],
                                                  trk_hdr[HDR_YOVF]), scr_h);
        c.x = cur_col[CW-1:0];
        c.y = cur_row[CW-1:0];
        c.l = trk_hdr[HDR_LEFT];
        c.m = trk_hdr[HDR_MIDDLE];
        c.r = trk_hdr[HDR_RIGHT];
        return 1'b1;
      end
      default: begin
        if (b[HDR_SYNC]) begin
          trk_hdr   = b;
          trk_phase = PH_XDELTA;
        end else begin
          trk_phase = PH_HEADER;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic stim_row_t row(logic [7:0] d);
    return '{data: d, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t row_exp(logic [7:0] d, int x, int y,
                                        logic l, logic m, logic r);
    cursor_t c;
    c = '{r: r, m: m, l: l, y: CW'(y), x: CW'(x)};
    return '{data: d, typed: 1'b1, want: c};
  endfunction

  // Handshake monitor: screen size on cfg writes, tracker update on accepted bytes, compare on result words
  always @(posedge clk) begin
    stim_row_t row_now;
    cursor_t   c;
    cursor_t   got;
    cursor_t   want;
    bit        has_row;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WIDTH:  scr_w = cfg_data;
          CFG_HEIGHT: scr_h = cfg_data;
          default:    ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        has_row = typed_q.size() != 0;
        if (has_row) row_now = typed_q.pop_front();
        if (track_byte(in_tdata, c))
          cursor_q.push_back((has_row && row_now.typed) ? row_now.want : c);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[2*CW+2:0];
        if (cursor_q.size() == 0) begin
          $error("unexpected cursor word %h", out_tdata);
          err_count++;
        end else begin
          want = cursor_q.pop_front();
          check_field("cursor_x", int'(want.x), int'(got.x));
          check_field("cursor_y", int'(want.y), int'(got.y));
          check_field("left_button", int'(want.l), int'(got.l));
          check_field("middle_button", int'(want.m), int'(got.m));
          check_field("right_button", int'(want.r), int'(got.r));
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait out all results plus pipeline latency, then realign to a header
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cursor_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (trk_phase != PH_HEADER) begin
      push_byte(8'($urandom_range(0, 255)));
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (cursor_q.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  task automatic write_screen(int w, int h);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_WIDTH;
    cfg_data <= CW'(w);
    @(posedge clk);
    cfg_addr <= CFG_HEIGHT;
    cfg_data <= CW'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink
  initial begin
    int stall;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = STALL_LONG;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Byte source
  initial begin
    int         p;
    int         k;
    int         w;
    int         h;
    logic [7:0] hb;
    // reset size 1024 x 768, cursor starts at 0,0
    directed_rows = '{
      row(8'h00),                                          // no sync bit, dropped
      row(8'h07),                                          // buttons but no sync
      row(8'h08), row(8'h00), row_exp(8'h00, 1, 1, 0, 0, 0),
      row(8'hE9), row(8'hFF), row_exp(8'h01, 511, 511, 1, 0, 0),
      row(8'hE9), row(8'hFF), row_exp(8'h01, 1021, 767, 1, 0, 0),
      row(8'hEF), row(8'hFF), row_exp(8'h01, 1023, 767, 1, 1, 1),
      row(8'h5C), row(8'h01), row_exp(8'hFF, 513, 512, 0, 1, 0),
      row(8'h3A), row(8'h00), row_exp(8'h00, 513, 512, 0, 0, 1),  // sign, zero byte
      row(8'hF8), row(8'h00), row_exp(8'h00, 258, 767, 0, 0, 0),
      row(8'h78), row(8'h01), row(8'h80)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      typed_q.push_back(directed_rows[i]);
      push_byte(directed_rows[i].data);
    end
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin w = 8191; h = 8191; end
        1: begin w = 2;    h = 2;    end
        2: begin w = 2;    h = 8191; end
        3: begin w = 8191; h = 2;    end
        4: begin w = $urandom_range(2, 8191); h = $urandom_range(2, 8191); end
        default: begin w = $urandom_range(2, 300); h = $urandom_range(2, 300); end
      endcase
      write_screen(w, h);
      no_idle  = (p == 2) || (p == 3);
      hold_req = (p == 3);
      for (k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
        hb = 8'($urandom_range(0, 255));
        hb[HDR_SYNC] = 1'b1;
        if ($urandom_range(0, 3) != 0) begin
          hb[HDR_XOVF] = 1'b0;
          hb[HDR_YOVF] = 1'b0;
        end
        push_byte(hb);
        push_byte(8'($urandom_range(0, 255)));
        // occasionally cut the packet short
        if ($urandom_range(0, 19) != 0) push_byte(8'($urandom_range(0, 255)));
      end
    end
    settle();
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
